/* rtl/vefs_pkg.sv */
// ============================================================================
// vefs_pkg - shared types and constants of the vsync fan-out scheduler
// Op codes, status codes, table sizes and the sequencer state type.
// ============================================================================
`default_nettype none

package vefs_pkg;

    localparam int NUM_SLOTS    = 16;
    localparam int RATE_BITS    = 8;
    localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_FIELD_W = 4;
    localparam int OP_W         = 3;
    localparam int MASK_W       = 16;
    localparam int STAMP_W      = 63;
    localparam int COUNT_W      = 64;
    localparam int BIT_CNT_W    = $clog2(COUNT_W);
    // normal rate carries a sign: -1 idle, 0 one-shot, N periodic
    localparam int SRATE_W      = RATE_BITS + 1;

    typedef logic [SLOT_W-1:0]     slot_idx_t;
    typedef logic [RATE_BITS-1:0]  rate_t;
    typedef logic [SRATE_W-1:0]    srate_t;
    typedef logic [COUNT_W-1:0]    count_t;

    localparam srate_t RATE_IDLE = '1;

    localparam logic [OP_W-1:0] OP_VSYNC    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_REQ_NEXT = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_RATE = 3'd4;
    localparam logic [OP_W-1:0] OP_SET_HIGH = 3'd5;
    localparam logic [OP_W-1:0] OP_POST_ERR = 3'd6;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_INVAL = 1'b1;

    localparam logic FAIL_BLOCK = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CHECK,
        ST_MOD,
        ST_DONE
    } state_t;

    // status of the shared modulo unit
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } mod_stat_t;

endpackage

`default_nettype wire

/* rtl/vefs_mod_unit.sv */
// ============================================================================
// vefs_mod_unit - serial remainder of the frame count by a rate
// Restoring division, one dividend bit per cycle; flags a zero remainder.
// ============================================================================
`default_nettype none

module vefs_mod_unit
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire vefs_pkg::count_t     dividend,
    input  wire vefs_pkg::rate_t      divisor,
    output vefs_pkg::mod_stat_t       mod_st
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [vefs_pkg::BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    vefs_pkg::count_t                dvd_reg, dvd_next;
    vefs_pkg::rate_t                 div_reg, div_next;
    vefs_pkg::rate_t                 rem_reg, rem_next;
    logic [vefs_pkg::RATE_BITS:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[vefs_pkg::COUNT_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = vefs_pkg::rate_t'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[vefs_pkg::RATE_BITS-1:0];
            end
            dvd_next = {dvd_reg[vefs_pkg::COUNT_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == vefs_pkg::BIT_CNT_W'(vefs_pkg::COUNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign mod_st.busy     = busy_reg;
    assign mod_st.done     = done_reg;
    assign mod_st.rem_zero = (rem_reg == '0);

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("modulo done without a finished run");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("modulo start while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("modulo done longer than one cycle");

endmodule

`default_nettype wire

/* rtl/vsync_event_fanout_scheduler_unit.sv */
// ============================================================================
// vsync_event_fanout_scheduler_unit - vsync fan-out scheduler, top level
// Slot table, op decode and a sequencer that walks all slots (effective rate > 0
// via one shared serial modulo unit) to build the delivery mask and wanted flag.
// ============================================================================
// Sequence: a non-vsync op is first applied to its slot (APPLY); then each of
//   the 16 slots takes a CHECK step, followed by a MOD wait on the 64-bit
//   serial modulo when the slot is valid and its effective rate is above zero;
//   DONE then loads the output register. One item at a time: the next is taken
//   once the result is loaded, and a result still stalled downstream holds DONE.
// Reset (rst_n, async, active low): slots invalid, rates idle, count zero.
`default_nettype none

module vsync_event_fanout_scheduler_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input item channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [vefs_pkg::OP_W-1:0]          op,
    input  wire logic [vefs_pkg::SLOT_FIELD_W-1:0]  slot,
    input  wire logic [7:0]                         rate_value,
    input  wire logic [vefs_pkg::STAMP_W-1:0]       stamp_in,
    input  wire logic                               fail_kind,
    // result item channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    status,
    output logic [vefs_pkg::MASK_W-1:0]             deliver_mask,
    output logic [vefs_pkg::STAMP_W-1:0]            stamp_out,
    output logic                                    vsync_wanted
);

    // ---------------------------------------------------------------- state
    vefs_pkg::state_t   state_reg, state_next;

    // slot table: one entry read and written per cycle, at idx_reg
    logic               valid_arr   [vefs_pkg::NUM_SLOTS];
    vefs_pkg::srate_t   rate_arr    [vefs_pkg::NUM_SLOTS];
    vefs_pkg::rate_t    high_arr    [vefs_pkg::NUM_SLOTS];
    logic               high_on_arr [vefs_pkg::NUM_SLOTS];

    vefs_pkg::count_t   count_reg, count_next;
    vefs_pkg::slot_idx_t idx_reg, idx_next;

    // latched item
    logic [vefs_pkg::OP_W-1:0]          op_reg, op_next;
    logic [vefs_pkg::SLOT_FIELD_W-1:0]  slot_reg, slot_next;
    vefs_pkg::rate_t                    rate_reg, rate_next;
    logic [vefs_pkg::STAMP_W-1:0]       stamp_reg, stamp_next;
    logic                               fail_reg, fail_next;
    logic                               deliver_reg, deliver_next;

    // walk accumulators
    logic [vefs_pkg::MASK_W-1:0]        mask_reg, mask_next;
    logic                               want_reg, want_next;
    logic                               stat_reg, stat_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic                               status_reg, status_next;
    logic [vefs_pkg::MASK_W-1:0]        dmask_reg, dmask_next;
    logic [vefs_pkg::STAMP_W-1:0]       stamp_out_reg, stamp_out_next;
    logic                               wanted_reg, wanted_next;

    // table write port
    logic               ent_we;
    logic               ent_valid;
    vefs_pkg::srate_t   ent_rate;
    vefs_pkg::rate_t    ent_high;
    logic               ent_high_on;

    // current entry
    logic               cur_valid;
    vefs_pkg::srate_t   cur_rate;
    vefs_pkg::rate_t    cur_high;
    logic               cur_high_on;
    vefs_pkg::srate_t   eff_rate;
    logic               eff_zero;
    logic               eff_pos;
    logic               slot_inside;
    logic               idx_last;

    // shared modulo unit
    logic                   mod_start;
    vefs_pkg::mod_stat_t    mod_st;

    logic               in_accept;

    assign in_accept   = in_valid && !in_stall;
    assign in_stall    = (state_reg != vefs_pkg::ST_IDLE);

    assign cur_valid   = valid_arr[idx_reg];
    assign cur_rate    = rate_arr[idx_reg];
    assign cur_high    = high_arr[idx_reg];
    assign cur_high_on = high_on_arr[idx_reg];

    // effective rate: high-priority rate when enabled, else the normal rate
    assign eff_rate    = cur_high_on ? {1'b0, cur_high} : cur_rate;
    assign eff_zero    = (eff_rate == '0);
    assign eff_pos     = !eff_rate[vefs_pkg::SRATE_W-1] && !eff_zero;

    assign slot_inside = (32'(slot_reg) < vefs_pkg::NUM_SLOTS);
    assign idx_last    = (idx_reg == vefs_pkg::slot_idx_t'(vefs_pkg::NUM_SLOTS - 1));

    vefs_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (count_reg),
        .divisor  (eff_rate[vefs_pkg::RATE_BITS-1:0]),
        .mod_st   (mod_st)
    );

    // ------------------------------------------------------- state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vefs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------- next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        rate_next      = rate_reg;
        stamp_next     = stamp_reg;
        fail_next      = fail_reg;
        deliver_next   = deliver_reg;
        mask_next      = mask_reg;
        want_next      = want_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        dmask_next     = dmask_reg;
        stamp_out_next = stamp_out_reg;
        wanted_next    = wanted_reg;
        ent_we         = 1'b0;
        ent_valid      = cur_valid;
        ent_rate       = cur_rate;
        ent_high       = cur_high;
        ent_high_on    = cur_high_on;
        mod_start      = 1'b0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            vefs_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next   = op;
                    slot_next = slot;
                    rate_next = rate_value[vefs_pkg::RATE_BITS-1:0];
                    fail_next = fail_kind;
                    mask_next = '0;
                    want_next = 1'b0;
                    stat_next = vefs_pkg::STATUS_OK;
                    if (op == vefs_pkg::OP_VSYNC)
                    begin
                        // walk runs on the advanced count
                        count_next   = count_reg + 1'b1;
                        stamp_next   = stamp_in;
                        deliver_next = (stamp_in != '0);
                        idx_next     = '0;
                        state_next   = vefs_pkg::ST_CHECK;
                    end
                    else
                    begin
                        stamp_next   = '0;
                        deliver_next = 1'b0;
                        idx_next     = vefs_pkg::slot_idx_t'(slot);
                        state_next   = vefs_pkg::ST_APPLY;
                    end
                end
            end

            vefs_pkg::ST_APPLY:
            begin
                if (!slot_inside)
                begin
                    stat_next = vefs_pkg::STATUS_INVAL;
                end
                else
                begin
                    case (op_reg)
                        vefs_pkg::OP_ADD:
                        begin
                            if (cur_valid)
                            begin
                                stat_next = vefs_pkg::STATUS_INVAL;
                            end
                            else
                            begin
                                ent_we    = 1'b1;
                                ent_valid = 1'b1;
                            end
                        end
                        vefs_pkg::OP_REMOVE:
                        begin
                            if (!cur_valid)
                            begin
                                stat_next = vefs_pkg::STATUS_INVAL;
                            end
                            else
                            begin
                                ent_we    = 1'b1;
                                ent_valid = 1'b0;
                            end
                        end
                        vefs_pkg::OP_REQ_NEXT:
                        begin
                            if (!cur_valid)
                            begin
                                stat_next = vefs_pkg::STATUS_INVAL;
                            end
                            else if (cur_rate[vefs_pkg::SRATE_W-1])
                            begin
                                ent_we   = 1'b1;
                                ent_rate = '0;
                            end
                        end
                        vefs_pkg::OP_SET_RATE:
                        begin
                            if (!cur_valid || rate_reg == '0 || cur_rate == {1'b0, rate_reg})
                            begin
                                stat_next = vefs_pkg::STATUS_INVAL;
                            end
                            else
                            begin
                                ent_we   = 1'b1;
                                ent_rate = {1'b0, rate_reg};
                            end
                        end
                        vefs_pkg::OP_SET_HIGH:
                        begin
                            if (!cur_valid || rate_reg == '0 || cur_high == rate_reg)
                            begin
                                stat_next = vefs_pkg::STATUS_INVAL;
                            end
                            else
                            begin
                                ent_we      = 1'b1;
                                ent_high    = rate_reg;
                                ent_high_on = 1'b1;
                            end
                        end
                        vefs_pkg::OP_POST_ERR:
                        begin
                            if (!cur_valid)
                            begin
                                stat_next = vefs_pkg::STATUS_INVAL;
                            end
                            else if (fail_reg == vefs_pkg::FAIL_BLOCK)
                            begin
                                // would block: arm a one-shot if idle
                                if (cur_rate[vefs_pkg::SRATE_W-1])
                                begin
                                    ent_we   = 1'b1;
                                    ent_rate = '0;
                                end
                            end
                            else
                            begin
                                ent_we    = 1'b1;
                                ent_valid = 1'b0;
                            end
                        end
                        default:
                        begin
                            stat_next = vefs_pkg::STATUS_INVAL;
                        end
                    endcase
                end
                idx_next   = '0;
                state_next = vefs_pkg::ST_CHECK;
            end

            vefs_pkg::ST_CHECK:
            begin
                if (cur_valid && eff_pos)
                begin
                    mod_start  = 1'b1;
                    state_next = vefs_pkg::ST_MOD;
                end
                else
                begin
                    // one-shot by effective rate zero; idle and absent slots miss
                    if (cur_valid && eff_zero)
                    begin
                        want_next = 1'b1;
                        if (deliver_reg)
                        begin
                            mask_next = mask_reg | (vefs_pkg::MASK_W'(1) << idx_reg);
                            ent_we    = 1'b1;
                            ent_rate  = vefs_pkg::RATE_IDLE;
                        end
                    end
                    if (idx_last)
                    begin
                        state_next = vefs_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            vefs_pkg::ST_MOD:
            begin
                if (mod_st.done)
                begin
                    // periodic hit needs a non-idle normal rate
                    if (mod_st.rem_zero && !cur_rate[vefs_pkg::SRATE_W-1])
                    begin
                        want_next = 1'b1;
                        if (deliver_reg)
                        begin
                            mask_next = mask_reg | (vefs_pkg::MASK_W'(1) << idx_reg);
                            if (cur_rate == '0)
                            begin
                                ent_we   = 1'b1;
                                ent_rate = vefs_pkg::RATE_IDLE;
                            end
                        end
                    end
                    if (idx_last)
                    begin
                        state_next = vefs_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = vefs_pkg::ST_CHECK;
                    end
                end
            end

            vefs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = stat_reg;
                    dmask_next     = mask_reg;
                    stamp_out_next = stamp_reg;
                    wanted_next    = want_reg;
                    state_next     = vefs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vefs_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------ control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < vefs_pkg::NUM_SLOTS; i++)
            begin
                valid_arr[i]   <= 1'b0;
                rate_arr[i]    <= vefs_pkg::RATE_IDLE;
                high_arr[i]    <= '0;
                high_on_arr[i] <= 1'b0;
            end
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (ent_we)
            begin
                valid_arr[idx_reg]   <= ent_valid;
                rate_arr[idx_reg]    <= ent_rate;
                high_arr[idx_reg]    <= ent_high;
                high_on_arr[idx_reg] <= ent_high_on;
            end
        end
    end

    // ------------------------------------------------------------ payload
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        op_reg        <= op_next;
        slot_reg      <= slot_next;
        rate_reg      <= rate_next;
        stamp_reg     <= stamp_next;
        fail_reg      <= fail_next;
        deliver_reg   <= deliver_next;
        mask_reg      <= mask_next;
        want_reg      <= want_next;
        stat_reg      <= stat_next;
        status_reg    <= status_next;
        dmask_reg     <= dmask_next;
        stamp_out_reg <= stamp_out_next;
        wanted_reg    <= wanted_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign deliver_mask = dmask_reg;
    assign stamp_out    = stamp_out_reg;
    assign vsync_wanted = wanted_reg;

    // --------------------------------------------------------- assertions
    a_mask_implies_vsync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (dmask_reg != '0) |->
            wanted_reg && (stamp_out_reg != '0) && (status_reg == vefs_pkg::STATUS_OK))
        else $error("delivery mask on a result that is not a delivered vsync");

    a_inval_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == vefs_pkg::STATUS_INVAL) |-> (dmask_reg == '0))
        else $error("rejected op reports deliveries");

    a_mod_only_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_st.busy |-> (state_reg == vefs_pkg::ST_MOD))
        else $error("modulo unit running outside its wait state");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (op == vefs_pkg::OP_VSYNC) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("frame count did not advance on vsync");

endmodule

`default_nettype wire
